### rtl/core/prim_mst_priority_first_search_core_macros.svh
// Assertion macros for the priority-first search core
`ifndef PRIM_MST_PRIORITY_FIRST_SEARCH_CORE_MACROS_SVH
`define PRIM_MST_PRIORITY_FIRST_SEARCH_CORE_MACROS_SVH

// Check that holds at every clock edge outside reset
`define PMPFS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that one condition implies another in the same cycle
`define PMPFS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/core/pmpfs_pkg.sv
// Shared constants and types for the priority-first search core
`default_nettype none
package pmpfs_pkg;
	localparam int MAX_V = 32;
	localparam int MAX_E = 256;
	localparam int WB    = 16;
	localparam int VW    = $clog2(MAX_V);
	localparam int EW    = $clog2(MAX_E);
	localparam int ETW   = EW + 1;
	localparam int NW    = VW + 1;
	localparam int HPW   = VW + 2;
	localparam int PW    = WB + 2;
	localparam int EDW   = 2 * VW + WB;
	localparam int CFGW  = 6;

	typedef logic signed [PW-1:0] prio_t;
	// priority of a vertex not yet seen in this run
	localparam prio_t NOT_SEEN = {1'b1, {(PW-2){1'b0}}, 1'b1};

	typedef enum logic [1:0] {
		MODE_ADD   = 2'd0,
		MODE_RUN   = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;
endpackage
`default_nettype wire

### rtl/core/pmpfs_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module pmpfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### rtl/core/prim_mst_priority_first_search_core.sv
// Top level of the priority-first search (Prim) minimum spanning forest core
// Edges go in one item per cycle (mode 0: add, mode 2: clear, mode 3: ignored) and
// are kept in a 256-entry edge RAM; an add to a full store is dropped and sets the
// sticky edges_dropped flag. A run item (mode 1) walks every vertex below the
// vertex count, clamped into 1..32, in visit order and gives one result item per
// vertex, last on the final one. During a run in_stall stays high. The run is done
// by one sequencer over a binary heap held in flip-flops, one heap step per cycle
// while no result waits on out_stall. Each visited vertex scans the whole edge
// store through the edge RAM read port, and an improved priority triggers a full
// bottom-up rebuild of up to heap/2 sift-downs. No clearing pass is needed after
// reset.
`default_nettype none
`include "prim_mst_priority_first_search_core_macros.svh"
module prim_mst_priority_first_search_core (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// APB-style configuration port
	input  wire logic                    psel,
	input  wire logic                    penable,
	input  wire logic                    pwrite,
	input  wire logic [2:0]              paddr,
	input  wire logic [31:0]             pwdata,
	output logic      [31:0]             prdata,
	output logic                         pready,
	// input items
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [1:0]              mode,
	input  wire logic [pmpfs_pkg::VW-1:0] end_a,
	input  wire logic [pmpfs_pkg::VW-1:0] end_b,
	input  wire logic [pmpfs_pkg::WB-1:0] edge_cost,
	// result items
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic      [pmpfs_pkg::VW-1:0] visited_vertex,
	output logic      [pmpfs_pkg::VW-1:0] tree_parent,
	output logic      [pmpfs_pkg::WB-1:0] link_cost,
	output logic                         is_root,
	output logic                         edges_dropped,
	output logic                         last
);
	import pmpfs_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_OUTER, ST_TAKE0, ST_TAKE1, ST_EMIT, ST_SCAN_RD, ST_SCAN_EV,
		ST_RELAX, ST_SU, ST_REB, ST_SD_START, ST_SD_LOOP, ST_SD_RIGHT, ST_SD_CMP
	} state_t;

	state_t state_q, ret_q;

	// configuration
	logic [CFGW-1:0] vcount_q;
	logic            cfg_wr;

	// edge store bookkeeping
	logic [ETW-1:0] etotal_q;
	logic           ovf_q;

	// vertex arrays, heap positions 1..MAX_V live at index pos-1
	prio_t          prio_q   [MAX_V];
	logic [VW-1:0]  heap_q   [MAX_V];
	logic [VW-1:0]  parent_q [MAX_V];

	// run registers
	logic [NW-1:0]  nv_q, r_q, n_q, hs_q;
	logic [VW-1:0]  u_q, to_q, v_q, ca_q;
	logic [HPW-1:0] k_q, c_q, rk_q;
	prio_t          pv_q, cp_q;
	logic [WB-1:0]  w_q;
	logic [ETW-1:0] e_q;

	// output register
	logic           out_valid_q;
	logic [VW-1:0]  vv_q, tp_q;
	logic [WB-1:0]  lc_q;
	logic           root_q, drop_q, last_q;
	logic           emit_go;

	// edge RAM
	logic           ram_we;
	logic [EW-1:0]  ram_raddr;
	logic [EDW-1:0] ram_rdata;
	logic [VW-1:0]  ed_a, ed_b;
	logic [WB-1:0]  ed_w;

	// heap / priority read ports
	logic [HPW-1:0] hrd_pos;
	logic [VW-1:0]  hdat;
	logic [VW-1:0]  prd_addr;
	prio_t          pdat, pneg, pnew;
	logic           in_acc, slot_free;
	logic [NW-1:0]  nv_clamp, hs_inc;
	logic [HPW-1:0] hs_ext, hs_half, k_half, k_dbl;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && (paddr[2] == 1'b0);
	assign prdata   = (paddr[2] == 1'b0) ? {{(32-CFGW){1'b0}}, vcount_q} : 32'd0;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign emit_go   = (state_q == ST_EMIT) && slot_free;

	assign out_valid      = out_valid_q;
	assign visited_vertex = vv_q;
	assign tree_parent    = tp_q;
	assign link_cost      = lc_q;
	assign is_root        = root_q;
	assign edges_dropped  = drop_q;
	assign last           = last_q;

	// vertex count clamped into 1..MAX_V
	always_comb begin
		if (vcount_q == '0) begin
			nv_clamp = NW'(1);
		end else if (NW'(vcount_q) > NW'(MAX_V)) begin
			nv_clamp = NW'(MAX_V);
		end else begin
			nv_clamp = NW'(vcount_q);
		end
	end

	assign ram_we = in_acc && (mode == MODE_ADD) && (etotal_q < ETW'(MAX_E));
	assign ram_raddr = EW'(e_q - 1'b1);
	assign {ed_a, ed_b, ed_w} = ram_rdata;

	pmpfs_ram #(
		.WIDTH (EDW),
		.DEPTH (MAX_E)
	) u_edge_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (etotal_q[EW-1:0]),
		.wdata ({end_a, end_b, edge_cost}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign hs_ext  = HPW'(hs_q);
	assign hs_half = hs_ext >> 1;
	assign k_half  = k_q >> 1;
	assign k_dbl   = k_q << 1;
	assign hs_inc  = hs_q + 1'b1;

	// one heap read a cycle, position chosen by the sequencer step
	always_comb begin
		case (state_q)
			ST_TAKE0:    hrd_pos = HPW'(1);
			ST_TAKE1:    hrd_pos = hs_ext;
			ST_SU:       hrd_pos = k_half;
			ST_SD_START: hrd_pos = k_q;
			ST_SD_LOOP:  hrd_pos = k_dbl;
			ST_SD_RIGHT: hrd_pos = c_q + 1'b1;
			default:     hrd_pos = HPW'(1);
		endcase
	end
	assign hdat = heap_q[VW'(hrd_pos - 1'b1)];

	always_comb begin
		case (state_q)
			ST_OUTER: prd_addr = r_q[VW-1:0];
			ST_EMIT:  prd_addr = u_q;
			ST_RELAX: prd_addr = to_q;
			default:  prd_addr = hdat;
		endcase
	end
	assign pdat = prio_q[prd_addr];
	assign pneg = -pdat;
	assign pnew = -prio_t'({2'b00, w_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			vcount_q    <= CFGW'(MAX_V);
			etotal_q    <= '0;
			ovf_q       <= 1'b0;
			hs_q        <= '0;
			nv_q        <= NW'(1);
			r_q         <= '0;
			n_q         <= '0;
			e_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				vcount_q <= pwdata[CFGW-1:0];
			end
			// a new result refills the slot in the cycle the old one leaves
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (mode)
							MODE_ADD: begin
								if (etotal_q < ETW'(MAX_E)) begin
									etotal_q <= etotal_q + 1'b1;
								end else begin
									ovf_q <= 1'b1;
								end
							end
							MODE_RUN: begin
								for (int i = 0; i < MAX_V; i++) begin
									prio_q[i] <= NOT_SEEN;
								end
								nv_q    <= nv_clamp;
								hs_q    <= '0;
								r_q     <= '0;
								n_q     <= '0;
								state_q <= ST_OUTER;
							end
							MODE_CLEAR: begin
								etotal_q <= '0;
								ovf_q    <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				ST_OUTER: begin
					if (r_q == nv_q) begin
						state_q <= ST_IDLE;
					end else if (pdat != NOT_SEEN) begin
						r_q <= r_q + 1'b1;
					end else begin
						// heap is empty here: the new root goes straight to the top
						heap_q[0] <= r_q[VW-1:0];
						hs_q      <= NW'(1);
						state_q   <= ST_TAKE0;
					end
				end
				ST_TAKE0: begin
					u_q     <= hdat;
					state_q <= ST_TAKE1;
				end
				ST_TAKE1: begin
					heap_q[0] <= hdat;
					hs_q      <= hs_q - 1'b1;
					k_q       <= HPW'(1);
					ret_q     <= ST_EMIT;
					state_q   <= ST_SD_START;
				end
				ST_EMIT: begin
					if (slot_free) begin
						prio_q[u_q] <= pneg;
						vv_q        <= u_q;
						root_q      <= ({1'b0, u_q} == r_q);
						tp_q        <= ({1'b0, u_q} == r_q) ? '0 : parent_q[u_q];
						lc_q        <= ({1'b0, u_q} == r_q) ? '0 : pneg[WB-1:0];
						drop_q      <= ovf_q;
						last_q      <= (n_q == nv_q - 1'b1);
						n_q         <= n_q + 1'b1;
						e_q         <= etotal_q;
						state_q     <= ST_SCAN_RD;
					end
				end
				ST_SCAN_RD: begin
					// newest edge first
					if (e_q == '0) begin
						state_q <= (hs_q != '0) ? ST_TAKE0 : ST_OUTER;
					end else begin
						e_q     <= e_q - 1'b1;
						state_q <= ST_SCAN_EV;
					end
				end
				ST_SCAN_EV: begin
					if ((NW'(ed_a) >= nv_q) || (NW'(ed_b) >= nv_q)) begin
						state_q <= ST_SCAN_RD;
					end else if ((ed_a == u_q) || (ed_b == u_q)) begin
						to_q    <= (ed_b == u_q) ? ed_a : ed_b;
						w_q     <= ed_w;
						state_q <= ST_RELAX;
					end else begin
						state_q <= ST_SCAN_RD;
					end
				end
				ST_RELAX: begin
					state_q <= ST_SCAN_RD;
					if (pdat < 0) begin
						if (pdat == NOT_SEEN) begin
							heap_q[VW'(hs_q)] <= to_q;
							prio_q[to_q]      <= pnew;
							parent_q[to_q]    <= u_q;
							hs_q              <= hs_inc;
							k_q               <= HPW'(hs_inc);
							v_q               <= to_q;
							pv_q              <= pnew;
							state_q           <= ST_SU;
						end else if (pdat < pnew) begin
							prio_q[to_q]   <= pnew;
							parent_q[to_q] <= u_q;
							rk_q           <= hs_half;
							state_q        <= ST_REB;
						end
					end
				end
				ST_SU: begin
					// equal priority still moves up
					if ((k_half == '0) || (pdat > pv_q)) begin
						heap_q[VW'(k_q - 1'b1)] <= v_q;
						state_q                 <= ST_SCAN_RD;
					end else begin
						heap_q[VW'(k_q - 1'b1)] <= hdat;
						k_q                     <= k_half;
					end
				end
				ST_REB: begin
					if (rk_q == '0) begin
						state_q <= ST_SCAN_RD;
					end else begin
						k_q     <= rk_q;
						rk_q    <= rk_q - 1'b1;
						ret_q   <= ST_REB;
						state_q <= ST_SD_START;
					end
				end
				ST_SD_START: begin
					v_q     <= hdat;
					pv_q    <= pdat;
					state_q <= ST_SD_LOOP;
				end
				ST_SD_LOOP: begin
					if (k_q > hs_half) begin
						heap_q[VW'(k_q - 1'b1)] <= v_q;
						state_q                 <= ret_q;
					end else begin
						ca_q    <= hdat;
						cp_q    <= pdat;
						c_q     <= k_dbl;
						state_q <= (k_dbl < hs_ext) ? ST_SD_RIGHT : ST_SD_CMP;
					end
				end
				ST_SD_RIGHT: begin
					// right child only when strictly larger
					if (cp_q < pdat) begin
						ca_q <= hdat;
						cp_q <= pdat;
						c_q  <= c_q + 1'b1;
					end
					state_q <= ST_SD_CMP;
				end
				ST_SD_CMP: begin
					if (pv_q >= cp_q) begin
						heap_q[VW'(k_q - 1'b1)] <= v_q;
						state_q                 <= ret_q;
					end else begin
						heap_q[VW'(k_q - 1'b1)] <= ca_q;
						k_q                     <= c_q;
						state_q                 <= ST_SD_LOOP;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`PMPFS_ASSERT_IMP(a_idle_heap_empty, state_q == ST_IDLE, hs_q == '0, "heap not empty when idle")
	`PMPFS_ASSERT(a_heap_bound, hs_q <= nv_q, "heap larger than vertex count")
	`PMPFS_ASSERT(a_emit_bound, n_q <= nv_q, "more results than vertices")
endmodule
`default_nettype wire

### tb/prim_mst_priority_first_search_core_tb.sv
// Self-checking testbench for the priority-first search spanning forest core
`timescale 1ns / 100ps
module prim_mst_priority_first_search_core_tb;
	import pmpfs_pkg::*;

	localparam longint UNSEEN    = -((longint'(1) << (WB + 1)) - 1);
	localparam int     CYCLE_CAP = 3000000;
	localparam int     SETTLE    = 200;   // idle cycles after the last tree item

	typedef struct {
		mode_t       op;
		logic [4:0]  a;
		logic [4:0]  b;
		logic [15:0] cost;
	} edge_item_t;

	typedef struct {
		logic [4:0]  vtx;
		logic [4:0]  par;
		logic [15:0] cost;
		logic        root;
		logic        dropped;
		logic        fin;
	} tree_item_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic in_valid, in_stall;
	logic [1:0] mode;
	logic [4:0] end_a, end_b;
	logic [15:0] edge_cost;
	logic out_valid, out_stall;
	logic [4:0] visited_vertex, tree_parent;
	logic [15:0] link_cost;
	logic is_root, edges_dropped, last;

	prim_mst_priority_first_search_core dut (.*);

	always begin
		clk = 1'b1; #4;
		clk = 1'b0; #4;
	end

	// items waiting to be sent, tree items waiting to be seen
	edge_item_t edge_q[$];
	tree_item_t tree_q[$];
	int errors = 0;
	int cycles = 0;

	// ---------------------------------------------------------------
	// Shadow of the core: edge store, vertex_count and the heap walk
	// ---------------------------------------------------------------
	logic [5:0]  vtx_count;
	logic [4:0]  store_a [MAX_E];
	logic [4:0]  store_b [MAX_E];
	logic [15:0] store_w [MAX_E];
	int          store_n;
	logic        store_full_seen;
	longint      prio [MAX_V];
	int          heap [MAX_V + 1];
	int          heap_n;
	int          parent [MAX_V];

	function automatic void heap_up(int k);
		int v;
		v = heap[k];
		while (k / 2 > 0 && prio[heap[k / 2]] <= prio[v]) begin
			heap[k] = heap[k / 2];
			k = k / 2;
		end
		heap[k] = v;
	endfunction

	function automatic void heap_down(int k);
		int v, c;
		v = heap[k];
		while (k <= heap_n / 2) begin
			c = 2 * k;
			// right child only when strictly larger
			if (c < heap_n && prio[heap[c]] < prio[heap[c + 1]])
				c++;
			if (prio[v] >= prio[heap[c]])
				break;
			heap[k] = heap[c];
			k = c;
		end
		heap[k] = v;
	endfunction

	function automatic bit heap_offer(int v, longint p);
		if (prio[v] == UNSEEN) begin
			heap_n++;
			heap[heap_n] = v;
			prio[v] = p;
			heap_up(heap_n);
			return 1'b1;
		end
		if (prio[v] < p) begin
			prio[v] = p;
			// full bottom-up rebuild after an improvement
			for (int k = heap_n / 2; k >= 1; k--)
				heap_down(k);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic int heap_take();
		int v;
		v = heap[1];
		heap[1] = heap[heap_n];
		heap_n--;
		heap_down(1);
		return v;
	endfunction

	function automatic void try_link(int from, int to, logic [15:0] w);
		if (prio[to] < 0 && heap_offer(to, -longint'(w)))
			parent[to] = from;
	endfunction

	// Prim walk over all vertices; pushes one tree item per vertex
	function automatic void walk_forest();
		int nv, u, a, b;
		tree_item_t t;
		nv = vtx_count;
		if (nv < 1) nv = 1;
		if (nv > MAX_V) nv = MAX_V;
		for (int r = 0; r < nv; r++) begin
			prio[r] = UNSEEN;
			parent[r] = 0;
		end
		heap_n = 0;
		for (int r = 0; r < nv; r++) begin
			if (prio[r] != UNSEEN)
				continue;
			void'(heap_offer(r, UNSEEN));
			while (heap_n != 0) begin
				u = heap_take();
				prio[u] = -prio[u];
				t.vtx = u[4:0];
				t.root = (u == r);
				t.par = t.root ? 5'd0 : parent[u][4:0];
				t.cost = t.root ? 16'd0 : prio[u][15:0];
				t.dropped = store_full_seen;
				t.fin = 1'b0;
				tree_q.push_back(t);
				// neighbours in reverse insertion order
				for (int e = store_n; e > 0; e--) begin
					a = store_a[e - 1];
					b = store_b[e - 1];
					if (a >= nv || b >= nv)
						continue;
					if (b == u) try_link(u, a, store_w[e - 1]);
					if (a == u) try_link(u, b, store_w[e - 1]);
				end
			end
		end
		tree_q[$].fin = 1'b1;
	endfunction

	function automatic void apply_item(edge_item_t it);
		case (it.op)
			MODE_ADD: begin
				if (store_n >= MAX_E) begin
					store_full_seen = 1'b1;
				end else begin
					store_a[store_n] = it.a;
					store_b[store_n] = it.b;
					store_w[store_n] = it.cost;
					store_n++;
				end
			end
			MODE_RUN: walk_forest();
			MODE_CLEAR: begin
				store_n = 0;
				store_full_seen = 1'b0;
			end
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Input driver: bursts and gaps, change on the falling edge
	// ---------------------------------------------------------------
	bit took;
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			apply_item(edge_q.pop_front());
			took = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (!in_valid || took) begin
			took = 1'b0;
			if (burst_left == 0 && gap_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			end
			if (gap_left > 0 || edge_q.size() == 0 || !arst_n) begin
				if (gap_left > 0) gap_left--;
				in_valid <= 1'b0;
			end else begin
				burst_left--;
				in_valid <= 1'b1;
				mode <= edge_q[0].op;
				end_a <= edge_q[0].a;
				end_b <= edge_q[0].b;
				edge_cost <= edge_q[0].cost;
			end
		end
	end

	// ---------------------------------------------------------------
	// Result side: stall pattern that shifts between phases
	// ---------------------------------------------------------------
	int stall_style = 0;
	int stall_hold = 0;

	always @(negedge clk) begin
		if (stall_hold == 0) begin
			stall_style = $urandom_range(0, 3);
			stall_hold = $urandom_range(10, 200);
		end
		stall_hold--;
		case (stall_style)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 1) == 0);
			default: out_stall <= (stall_hold % 8) < 5;
		endcase
	end

	// ---------------------------------------------------------------
	// Monitor: compare each tree item with the oldest prediction
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		tree_item_t want;
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("[FAIL] regression broken");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (tree_q.size() == 0) begin
				$error("unexpected tree item: vertex %0d", visited_vertex);
				errors++;
			end else begin
				want = tree_q.pop_front();
				if (visited_vertex !== want.vtx) begin
					$error("visited_vertex: expected %0d, got %0d", want.vtx, visited_vertex);
					errors++;
				end
				if (tree_parent !== want.par) begin
					$error("tree_parent: expected %0d, got %0d", want.par, tree_parent);
					errors++;
				end
				if (link_cost !== want.cost) begin
					$error("link_cost: expected %0d, got %0d", want.cost, link_cost);
					errors++;
				end
				if (is_root !== want.root) begin
					$error("is_root: expected %0d, got %0d", want.root, is_root);
					errors++;
				end
				if (edges_dropped !== want.dropped) begin
					$error("edges_dropped: expected %0d, got %0d", want.dropped,
						edges_dropped);
					errors++;
				end
				if (last !== want.fin) begin
					$error("last: expected %0d, got %0d", want.fin, last);
					errors++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	task automatic queue_item(mode_t op, int a, int b, int cost);
		edge_item_t it;
		it.op = op;
		it.a = a[4:0];
		it.b = b[4:0];
		it.cost = cost[15:0];
		edge_q.push_back(it);
	endtask

	// register writes only once the core has gone quiet
	task automatic set_vertices(int val);
		while (edge_q.size() != 0 || tree_q.size() != 0 || in_valid || in_stall)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		vtx_count = val[5:0];
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// random cost: wide spread, small for ties, rare zero
	function automatic int pick_cost();
		case ($urandom_range(0, 9))
			0: return 0;
			1, 2, 3: return $urandom_range(1, 6);
			default: return $urandom_range(1, 65535);
		endcase
	endfunction

	initial begin
		int sent, nv, n_add, span, vsel;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_valid = 1'b0; mode = MODE_NONE; end_a = '0; end_b = '0; edge_cost = '0;
		out_stall = 1'b0;
		vtx_count = 6'd32;
		store_n = 0;
		store_full_seen = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, self loop, zero weight, ties, unused mode
		queue_item(MODE_ADD, 0, 31, 65535);
		queue_item(MODE_ADD, 31, 5, 1);
		queue_item(MODE_ADD, 5, 5, 7);
		queue_item(MODE_ADD, 2, 3, 0);
		queue_item(MODE_ADD, 1, 2, 7);
		queue_item(MODE_ADD, 2, 1, 7);
		queue_item(MODE_ADD, 3, 1, 7);
		queue_item(MODE_NONE, 31, 31, 65535);
		queue_item(MODE_RUN, 0, 0, 0);
		set_vertices(4);              // edges touching 5 and 31 now outside
		queue_item(MODE_RUN, 31, 31, 65535);
		queue_item(MODE_CLEAR, 0, 0, 0);
		queue_item(MODE_RUN, 0, 0, 0);
		set_vertices(1);
		queue_item(MODE_ADD, 0, 0, 3);
		queue_item(MODE_RUN, 0, 0, 0);
		set_vertices(0);              // clamped up to one vertex
		queue_item(MODE_RUN, 0, 0, 0);
		set_vertices(63);             // clamped down to all vertices
		queue_item(MODE_RUN, 0, 0, 0);

		// store full: fill past capacity on a small graph, then run
		set_vertices(5);
		queue_item(MODE_CLEAR, 0, 0, 0);
		for (int i = 0; i < MAX_E + 3; i++)
			queue_item(MODE_ADD, $urandom_range(0, 31), $urandom_range(0, 5), pick_cost());
		queue_item(MODE_RUN, 0, 0, 0);
		queue_item(MODE_ADD, 1, 2, 9);   // still dropped, flag stays
		queue_item(MODE_RUN, 0, 0, 0);
		queue_item(MODE_CLEAR, 0, 0, 0);
		queue_item(MODE_RUN, 0, 0, 0);

		// random phases: new vertex count, a graph, a run
		sent = 0;
		while (sent < 200) begin
			vsel = $urandom_range(0, 9);
			nv = (vsel == 0) ? 32 : (vsel == 1) ? 1 : $urandom_range(1, 32);
			if ($urandom_range(0, 3) != 0) set_vertices(nv);
			else nv = (vtx_count == 0) ? 1 : (vtx_count > 32) ? 32 : vtx_count;
			if (store_n > 40 || $urandom_range(0, 2) != 0) begin
				queue_item(MODE_CLEAR, $urandom_range(0, 31), $urandom_range(0, 31),
					$urandom_range(0, 65535));
				sent++;
			end
			n_add = $urandom_range(0, 20);
			span = ($urandom_range(0, 4) == 0) ? 31 : ((nv + 1 > 31) ? 31 : nv + 1);
			for (int i = 0; i < n_add; i++) begin
				if ($urandom_range(0, 15) == 0)
					queue_item(MODE_NONE, $urandom_range(0, 31), $urandom_range(0, 31),
						$urandom_range(0, 65535));
				else
					queue_item(MODE_ADD, $urandom_range(0, span), $urandom_range(0, span),
						pick_cost());
				sent++;
			end
			queue_item(MODE_RUN, $urandom_range(0, 31), $urandom_range(0, 31),
				$urandom_range(0, 65535));
			sent++;
			// hold the sender back until the whole tree has drained
			if ($urandom_range(0, 3) == 0)
				while (edge_q.size() != 0 || tree_q.size() != 0) @(posedge clk);
		end

		while (edge_q.size() != 0 || tree_q.size() != 0 || in_valid || in_stall)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
